// ===== design/ascd_pkg.sv =====
`default_nettype none

package ascd_pkg;

  // Window geometry
  localparam int unsigned MaxHalf  = 8;
  localparam int unsigned WinDepth = 2 * MaxHalf + 1;

  // Field widths
  localparam int unsigned FrameW   = 32;
  localparam int unsigned ScoreW   = 16;
  localparam int unsigned ThrW     = 16;
  localparam int unsigned LenW     = 16;
  localparam int unsigned HalfRegW = 4;
  localparam int unsigned MinW     = 16;
  localparam int unsigned CfgW     = 16;
  localparam int unsigned CfgIdxW  = 2;

  // Derived widths
  localparam int unsigned HalfW = $clog2(MaxHalf + 1);
  localparam int unsigned FillW = $clog2(WinDepth + 1);
  localparam int unsigned SumW  = ScoreW + $clog2(WinDepth);
  localparam int unsigned ProdW = ThrW + SumW;

  // Register indexes
  localparam logic [CfgIdxW-1:0] RegRatio      = 2'd0;
  localparam logic [CfgIdxW-1:0] RegMinLen     = 2'd1;
  localparam logic [CfgIdxW-1:0] RegHalf       = 2'd2;
  localparam logic [CfgIdxW-1:0] RegMinContent = 2'd3;

  // Register reset values
  localparam logic [ThrW-1:0]     RatioReset      = 16'd768;
  localparam logic [LenW-1:0]     MinLenReset     = 16'd15;
  localparam logic [HalfRegW-1:0] HalfReset       = 4'd2;
  localparam logic [MinW-1:0]     MinContentReset = 16'd3840;

  // Ratio 255.0 in 8.8; a threshold above it can never be reached
  localparam logic [ThrW-1:0] RatioCap = 16'd65280;

  // Output queue
  localparam int unsigned FifoDepth = 8;
  localparam int unsigned FifoPtrW  = $clog2(FifoDepth);
  localparam int unsigned FifoCntW  = $clog2(FifoDepth + 1);

  // One window cell: the entry and the sum of all newer entries including itself
  typedef struct packed {
    logic [FrameW-1:0] frame;
    logic [ScoreW-1:0] score;
    logic [SumW-1:0]   prefix;
  } cell_t;

endpackage

`default_nettype wire

// ===== design/ascd_cell.sv =====
`default_nettype none

module ascd_cell (
  input  logic                         clk_i,
  input  logic                         shift_i,
  input  ascd_pkg::cell_t              prev_i,
  input  logic [ascd_pkg::ScoreW-1:0]  score_i,
  output ascd_pkg::cell_t              cell_o
);

  ascd_pkg::cell_t cell_d, cell_q;

  // Take the neighbor's entry and extend its prefix sum by the new score
  always_comb begin
    cell_d.frame  = prev_i.frame;
    cell_d.score  = prev_i.score;
    cell_d.prefix = prev_i.prefix + ascd_pkg::SumW'(score_i);
  end

  always_ff @(posedge clk_i) begin
    if (shift_i) begin
      cell_q <= cell_d;
    end
  end

  assign cell_o = cell_q;

endmodule

`default_nettype wire

// ===== design/ascd_fifo.sv =====
`default_nettype none

module ascd_fifo (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          push_i,
  input  logic [ascd_pkg::FrameW-1:0]   data_i,
  output logic                          valid_o,
  input  logic                          stall_i,
  output logic [ascd_pkg::FrameW-1:0]   data_o,
  output logic [ascd_pkg::FifoCntW-1:0] count_o
);

  logic [ascd_pkg::FrameW-1:0]   mem_q [ascd_pkg::FifoDepth];
  logic [ascd_pkg::FifoPtrW-1:0] wr_q, wr_d, rd_q, rd_d;
  logic [ascd_pkg::FifoCntW-1:0] cnt_q, cnt_d;
  logic                          pop;

  assign valid_o = (cnt_q != '0);
  assign pop     = valid_o & ~stall_i;
  assign data_o  = mem_q[rd_q];
  assign count_o = cnt_q;

  always_comb begin
    wr_d  = wr_q;
    rd_d  = rd_q;
    cnt_d = cnt_q;
    if (push_i) begin
      wr_d = (wr_q == ascd_pkg::FifoPtrW'(ascd_pkg::FifoDepth - 1)) ? '0
           : wr_q + ascd_pkg::FifoPtrW'(1);
    end
    if (pop) begin
      rd_d = (rd_q == ascd_pkg::FifoPtrW'(ascd_pkg::FifoDepth - 1)) ? '0
           : rd_q + ascd_pkg::FifoPtrW'(1);
    end
    if (push_i && !pop) begin
      cnt_d = cnt_q + ascd_pkg::FifoCntW'(1);
    end else if (pop && !push_i) begin
      cnt_d = cnt_q - ascd_pkg::FifoCntW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      wr_q  <= wr_d;
      rd_q  <= rd_d;
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_q] <= data_i;
    end
  end

endmodule

`default_nettype wire

// ===== design/adaptive_scene_cut_detector.sv =====
// Adaptive scene cut detector.
// Input channel: in_valid_i / in_stall_o carry one word per frame, the frame
// number and its 8.8 content score. Output channel: out_valid_o / out_stall_i
// carry one word per detected cut, the frame number of the cut frame.
// Configuration: cfg_we_i writes cfg_data_i into register cfg_index_i
// (0 ratio threshold, 1 minimum scene length, 2 half window, 3 minimum
// content score); write only while no frame is in flight.
// Throughput: one frame per cycle while in_stall_o is low. The score window is a row of 17 cells
// that shift on every accepted word, each keeping a prefix sum, so the
// window total is read off one cell; the test then runs through two
// register stages (select and subtract, cross multiply) and a final
// compare that also updates the last cut.
// A cut word passes the window cells, both stage registers and the queue before it reaches out_valid_o.
// When the receiver stalls, cut words collect in an 8-entry queue;
// in_stall_o rises once the queue plus the frames in flight could fill it.
// Reset clears the registers to their defaults, empties the window and the
// queue, and clears the last cut; the first frame after reset seeds it.
`default_nettype none

module adaptive_scene_cut_detector (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           in_valid_i,
  output logic                           in_stall_o,
  input  logic [ascd_pkg::FrameW-1:0]    frame_number_i,
  input  logic [ascd_pkg::ScoreW-1:0]    frame_score_i,
  output logic                           out_valid_o,
  input  logic                           out_stall_i,
  output logic [ascd_pkg::FrameW-1:0]    cut_frame_o,
  input  logic                           cfg_we_i,
  input  logic [ascd_pkg::CfgIdxW-1:0]   cfg_index_i,
  input  logic [ascd_pkg::CfgW-1:0]      cfg_data_i
);

  // Configuration registers
  logic [ascd_pkg::ThrW-1:0]     ratio_q;
  logic [ascd_pkg::LenW-1:0]     min_len_q;
  logic [ascd_pkg::HalfRegW-1:0] half_q;
  logic [ascd_pkg::MinW-1:0]     min_content_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ratio_q       <= ascd_pkg::RatioReset;
      min_len_q     <= ascd_pkg::MinLenReset;
      half_q        <= ascd_pkg::HalfReset;
      min_content_q <= ascd_pkg::MinContentReset;
    end else if (cfg_we_i) begin
      case (cfg_index_i)
        ascd_pkg::RegRatio:      ratio_q       <= cfg_data_i[ascd_pkg::ThrW-1:0];
        ascd_pkg::RegMinLen:     min_len_q     <= cfg_data_i[ascd_pkg::LenW-1:0];
        ascd_pkg::RegHalf:       half_q        <= cfg_data_i[ascd_pkg::HalfRegW-1:0];
        ascd_pkg::RegMinContent: min_content_q <= cfg_data_i[ascd_pkg::MinW-1:0];
        default: ;
      endcase
    end
  end

  // Effective half window, clamped to 1..MaxHalf
  logic [ascd_pkg::HalfW-1:0] eff_w;
  logic [ascd_pkg::HalfW:0]   twice_w;
  logic [ascd_pkg::FillW-1:0] span;

  always_comb begin
    if (half_q == '0) begin
      eff_w = ascd_pkg::HalfW'(1);
    end else if (32'(half_q) > ascd_pkg::MaxHalf) begin
      eff_w = ascd_pkg::HalfW'(ascd_pkg::MaxHalf);
    end else begin
      eff_w = ascd_pkg::HalfW'(half_q);
    end
    twice_w = {eff_w, 1'b0};
    span    = ascd_pkg::FillW'(32'(twice_w) + 1);
  end

  // Input handshake
  logic accept;
  logic v0_q, v1_q, v2_q;
  logic [ascd_pkg::FifoCntW-1:0] fifo_cnt;
  logic [ascd_pkg::FifoCntW:0]   pending;

  // Hold off input while queued cuts plus frames in flight could fill the queue
  assign pending = {1'b0, fifo_cnt} + (ascd_pkg::FifoCntW+1)'(v0_q)
                 + (ascd_pkg::FifoCntW+1)'(v1_q) + (ascd_pkg::FifoCntW+1)'(v2_q);
  assign in_stall_o = (pending >= (ascd_pkg::FifoCntW+1)'(ascd_pkg::FifoDepth));
  assign accept     = in_valid_i & ~in_stall_o;

  // Window: row of cells, newest at cell 0
  ascd_pkg::cell_t cells [ascd_pkg::WinDepth];
  ascd_pkg::cell_t head;

  always_comb begin
    head.frame  = frame_number_i;
    head.score  = frame_score_i;
    head.prefix = '0;
  end

  for (genvar k = 0; k < ascd_pkg::WinDepth; k++) begin : g_cell
    if (k == 0) begin : g_head
      ascd_cell u_cell (
        .clk_i   (clk_i),
        .shift_i (accept),
        .prev_i  (head),
        .score_i (frame_score_i),
        .cell_o  (cells[k])
      );
    end else begin : g_body
      ascd_cell u_cell (
        .clk_i   (clk_i),
        .shift_i (accept),
        .prev_i  (cells[k-1]),
        .score_i (frame_score_i),
        .cell_o  (cells[k])
      );
    end
  end

  logic [ascd_pkg::FillW-1:0] fill_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fill_q <= '0;
      v0_q   <= 1'b0;
    end else begin
      v0_q <= accept;
      if (accept && (fill_q < ascd_pkg::FillW'(ascd_pkg::WinDepth))) begin
        fill_q <= fill_q + ascd_pkg::FillW'(1);
      end
    end
  end

  // Stage 1: pick the middle entry and the window total, form the neighbor sum
  logic [ascd_pkg::ScoreW-1:0] mid_score;
  logic [ascd_pkg::FrameW-1:0] mid_frame;
  logic [ascd_pkg::SumW-1:0]   total;

  always_comb begin
    mid_score = '0;
    mid_frame = '0;
    total     = '0;
    for (int k = 0; k < ascd_pkg::WinDepth; k++) begin
      if (32'(eff_w) == k) begin
        mid_score = mid_score | cells[k].score;
        mid_frame = mid_frame | cells[k].frame;
      end
      if (32'(twice_w) == k) begin
        total = total | cells[k].prefix;
      end
    end
  end

  logic                        test1_q, pass1_q;
  logic [ascd_pkg::ScoreW-1:0] mid1_q;
  logic [ascd_pkg::FrameW-1:0] mframe1_q, cur1_q;
  logic [ascd_pkg::SumW-1:0]   others1_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
    end else begin
      v1_q <= v0_q;
    end
  end

  always_ff @(posedge clk_i) begin
    test1_q   <= (fill_q >= span);
    pass1_q   <= (mid_score >= min_content_q) && (ratio_q <= ascd_pkg::RatioCap);
    mid1_q    <= mid_score;
    mframe1_q <= mid_frame;
    cur1_q    <= cells[0].frame;
    others1_q <= total - ascd_pkg::SumW'(mid_score);
  end

  // Stage 2: cross multiply
  logic [ascd_pkg::ScoreW+ascd_pkg::HalfW:0] mid_times;
  logic [ascd_pkg::ProdW-1:0]                lhs_d, rhs_d;

  always_comb begin
    mid_times = (ascd_pkg::ScoreW+ascd_pkg::HalfW+1)'(mid1_q) * twice_w;
    lhs_d     = ascd_pkg::ProdW'({mid_times, 8'b0});
    rhs_d     = ratio_q * others1_q;
  end

  logic                        test2_q, pass2_q;
  logic [ascd_pkg::FrameW-1:0] mframe2_q, cur2_q;
  logic [ascd_pkg::ProdW-1:0]  lhs2_q, rhs2_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v2_q <= 1'b0;
    end else begin
      v2_q <= v1_q;
    end
  end

  always_ff @(posedge clk_i) begin
    test2_q   <= test1_q;
    pass2_q   <= pass1_q;
    mframe2_q <= mframe1_q;
    cur2_q    <= cur1_q;
    lhs2_q    <= lhs_d;
    rhs2_q    <= rhs_d;
  end

  // Stage 3: scene length against the last cut, decide and record
  logic [ascd_pkg::FrameW-1:0] lc_q, last_eff, gap;
  logic                        lc_valid_q;
  logic                        length_ok, cut;

  always_comb begin
    last_eff  = lc_valid_q ? lc_q : cur2_q;
    gap       = cur2_q - last_eff;
    length_ok = (gap >= ascd_pkg::FrameW'(min_len_q));
    cut       = v2_q & test2_q & pass2_q & (lhs2_q >= rhs2_q) & length_ok;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      lc_q       <= '0;
      lc_valid_q <= 1'b0;
    end else if (v2_q) begin
      lc_valid_q <= 1'b1;
      if (cut) begin
        lc_q <= mframe2_q;
      end else if (!lc_valid_q) begin
        lc_q <= cur2_q;
      end
    end
  end

  ascd_fifo u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (cut),
    .data_i  (mframe2_q),
    .valid_o (out_valid_o),
    .stall_i (out_stall_i),
    .data_o  (cut_frame_o),
    .count_o (fifo_cnt)
  );

  // Checks
  a_queue_room: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cut |-> (fifo_cnt < ascd_pkg::FifoCntW'(ascd_pkg::FifoDepth)))
    else $error("cut word pushed into a full queue");

  a_cut_recorded: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cut |=> (lc_q == $past(mframe2_q)))
    else $error("last cut not updated after a cut");

  a_seed_holds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    lc_valid_q |=> lc_valid_q)
    else $error("last cut seed lost");

  a_accept_tracked: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |=> v0_q)
    else $error("accepted word not tracked in flight");

endmodule

`default_nettype wire
